// ----- hdl/lfu_cache_policy_top_macros.svh -----
// ----------------------------------------------------------------------------
// LFU cache policy assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_POLICY_TOP_MACROS_SVH
`define LFU_CACHE_POLICY_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define LFU_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("lfu assertion failed");
`define LFU_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("lfu assertion failed");
`else
`define LFU_ASSERT_NOW(lbl, pre, post)
`define LFU_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ----- hdl/lfu_pkg.sv -----
// ----------------------------------------------------------------------------
// LFU cache policy package
// Word types, entry layout, sequencer states and shared constants.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int CFG_W        = 5;
  localparam int DATA_W       = 32;
  localparam int COUNT_W      = 32;
  localparam int STAMP_W      = 64;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [COUNT_W-1:0]       count_t;
  typedef logic [STAMP_W-1:0]       stamp_t;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);
  localparam logic             REQ_GET   = 1'b0;
  localparam logic             REQ_PUT   = 1'b1;
  localparam data_t            READ_MISS = -32'sd1;
  localparam count_t           COUNT_ONE = COUNT_W'(1);
  localparam count_t           COUNT_MAX = '1;

  typedef struct packed {
    logic  req_type;
    data_t key;
    data_t value;
  } req_t;

  typedef struct packed {
    logic  hit;
    data_t read_value;
    logic  evicted;
    data_t evicted_key;
  } rsp_t;

  typedef struct packed {
    data_t  key;
    data_t  value;
    count_t count;
    stamp_t stamp;
  } entry_t;

  // Current replacement candidate held by the sequencer.
  typedef struct packed {
    logic   valid;
    count_t count;
    stamp_t stamp;
  } best_t;

  typedef struct packed {
    logic match;
    logic better;
    logic free;
  } cmp_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_COMMIT,
    ST_RESULT
  } state_t;

  localparam rsp_t RSP_NONE = '{hit: 1'b0, read_value: READ_MISS,
                                evicted: 1'b0, evicted_key: '0};

endpackage

// ----- hdl/lfu_cache_policy_top.sv -----
// ----------------------------------------------------------------------------
// LFU cache policy top
// Fully associative key/value store with least-frequently-used replacement and
// least-recently-touched tie break. Each request word is a get or a put and
// yields one response word. A request is scanned one entry per cycle through
// the entry memory's single read port and one shared compare unit, which looks
// for the key, the victim and the first free slot at once. ST_LAST, ST_COMMIT
// and ST_RESULT follow the scan; with the capacity register at zero a request
// goes straight to ST_RESULT. The next request is taken while a response still
// waits on a stalled output. Configuration writes are always ready; the user
// must make them only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`include "lfu_cache_policy_top_macros.svh"

module lfu_cache_policy_top
  import lfu_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  state_t state, state_next;

  logic [CFG_W-1:0]    cap_reg;
  logic [CAPACITY-1:0] valid;
  logic [CAPACITY-1:0] valid_next;
  stamp_t              touch_clock;
  logic [OCC_W-1:0]    occupancy;

  logic [IDX_W-1:0] scan_idx;
  logic             chk_valid;
  logic [IDX_W-1:0] chk_idx;
  req_t             req_q;

  logic             found;
  logic [IDX_W-1:0] hit_idx;
  entry_t           hit_ent;
  logic             best_valid;
  logic [IDX_W-1:0] best_idx;
  count_t           best_count;
  stamp_t           best_stamp;
  data_t            best_key;
  logic             free_valid;
  logic [IDX_W-1:0] free_idx;
  rsp_t             res_q;

  logic     req_accept;
  logic     scan_en;
  logic     commit;
  logic     rsp_load;
  logic     cap_zero;
  logic     full;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] cap_lim;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  best_t            best;
  cmp_res_t         cres;

  logic             evict;
  logic             insert;
  logic [IDX_W-1:0] ins_idx;
  stamp_t           stamp_next;
  count_t           count_bump;
  rsp_t             res_next;

  assign cfg_ready  = 1'b1;
  assign req_accept = req_valid && !req_stall;
  assign cap_zero   = cap_reg == '0;
  assign cap_ext    = CMP_W'(cap_reg);
  assign cap_lim    = (cap_ext > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : cap_ext;
  assign full       = CMP_W'(occupancy) >= cap_lim;
  assign best       = '{valid: best_valid, count: best_count, stamp: best_stamp};

  lfu_entry_ram #(
    .DEPTH(CAPACITY),
    .AW   (IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(scan_idx),
    .rdata(ram_rdata)
  );

  lfu_cmp_unit u_cmp (
    .ent_valid(valid[chk_idx]),
    .ent      (ram_rdata),
    .key      (req_q.key),
    .best     (best),
    .res      (cres)
  );

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = cap_zero ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_idx == LAST_IDX) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST:   state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_RESULT;
      ST_RESULT: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    req_stall = 1'b1;
    scan_en   = 1'b0;
    commit    = 1'b0;
    rsp_load  = 1'b0;
    unique case (state)
      ST_IDLE:   req_stall = 1'b0;
      ST_SCAN:   scan_en   = 1'b1;
      ST_LAST:   ;
      ST_COMMIT: commit    = 1'b1;
      ST_RESULT: rsp_load  = !(rsp_valid && rsp_stall);
      default:   ;
    endcase
  end

  // Update of the hit entry or insertion of a new one, chosen after the scan.
  always_comb begin
    stamp_next = touch_clock + STAMP_W'(1);
    count_bump = (hit_ent.count == COUNT_MAX) ? hit_ent.count
                                              : COUNT_W'(hit_ent.count + COUNT_ONE);
    evict      = 1'b0;
    insert     = 1'b0;
    ins_idx    = free_idx;
    ram_we     = 1'b0;
    ram_waddr  = hit_idx;
    ram_wdata  = hit_ent;
    res_next   = RSP_NONE;
    if (found) begin
      ram_we          = commit;
      ram_wdata.count = count_bump;
      ram_wdata.stamp = stamp_next;
      res_next.hit    = 1'b1;
      if (req_q.req_type == REQ_PUT) begin
        ram_wdata.value = req_q.value;
      end else begin
        res_next.read_value = hit_ent.value;
      end
    end else if (req_q.req_type == REQ_PUT) begin
      evict = full && best_valid;
      // The freed victim slot competes with any lower free slot.
      if (evict && !(free_valid && (free_idx < best_idx))) begin
        ins_idx = best_idx;
      end
      insert    = evict || free_valid;
      ram_we    = commit && insert;
      ram_waddr = ins_idx;
      ram_wdata = '{key: req_q.key, value: req_q.value, count: COUNT_ONE,
                    stamp: stamp_next};
      if (evict) begin
        res_next.evicted     = 1'b1;
        res_next.evicted_key = best_key;
      end
    end
  end

  // The victim slot is cleared first so that a reuse of it ends up set.
  always_comb begin
    valid_next = valid;
    if (evict) begin
      valid_next[best_idx] = 1'b0;
    end
    if (insert) begin
      valid_next[ins_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cap_reg     <= CAP_RESET;
      valid       <= '0;
      touch_clock <= '0;
      occupancy   <= '0;
      scan_idx    <= '0;
      chk_valid   <= 1'b0;
      found       <= 1'b0;
      best_valid  <= 1'b0;
      free_valid  <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      chk_valid <= scan_en;
      if (cfg_valid && cfg_ready) begin
        cap_reg <= cfg_data;
      end
      if (req_accept) begin
        scan_idx <= '0;
      end else if (scan_en) begin
        scan_idx <= IDX_W'(scan_idx + 1'b1);
      end
      if (req_accept) begin
        found      <= 1'b0;
        best_valid <= 1'b0;
        free_valid <= 1'b0;
      end else if (chk_valid) begin
        if (cres.match) begin
          found <= 1'b1;
        end
        if (cres.better) begin
          best_valid <= 1'b1;
        end
        if (cres.free) begin
          free_valid <= 1'b1;
        end
      end
      if (commit) begin
        if (found || insert) begin
          touch_clock <= stamp_next;
        end
        valid     <= valid_next;
        occupancy <= OCC_W'(occupancy - OCC_W'(evict) + OCC_W'(insert));
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= scan_idx;
    if (req_accept) begin
      req_q <= req;
    end
    if (chk_valid) begin
      if (cres.match && !found) begin
        hit_idx <= chk_idx;
        hit_ent <= ram_rdata;
      end
      if (cres.better) begin
        best_idx   <= chk_idx;
        best_count <= ram_rdata.count;
        best_stamp <= ram_rdata.stamp;
        best_key   <= ram_rdata.key;
      end
      if (cres.free && !free_valid) begin
        free_idx <= chk_idx;
      end
    end
    if (req_accept && cap_zero) begin
      res_q <= RSP_NONE;
    end else if (commit) begin
      res_q <= res_next;
    end
    if (rsp_load) begin
      rsp <= res_q;
    end
  end

  `LFU_ASSERT_NOW(a_occ_matches_valid, 1'b1, $countones(valid) == int'(occupancy))
  `LFU_ASSERT_NOW(a_occ_bounded, 1'b1, occupancy <= OCC_W'(CAPACITY))
  `LFU_ASSERT_NOW(a_evict_only_put_miss, rsp_valid && rsp.evicted, !rsp.hit && (rsp.read_value == READ_MISS))
  `LFU_ASSERT_NEXT(a_accept_starts_work, req_accept, state != ST_IDLE)

endmodule

// ----- hdl/lfu_entry_ram.sv -----
// ----------------------------------------------------------------------------
// LFU entry memory
// One write port and one registered read port holding key, value, count, stamp.
// ----------------------------------------------------------------------------
module lfu_entry_ram
  import lfu_pkg::*;
#(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/lfu_cmp_unit.sv -----
// ----------------------------------------------------------------------------
// LFU compare unit
// Checks one stored entry against the request key and the current victim.
// ----------------------------------------------------------------------------
module lfu_cmp_unit
  import lfu_pkg::*;
(
  input  logic     ent_valid,
  input  entry_t   ent,
  input  data_t    key,
  input  best_t    best,
  output cmp_res_t res
);

  logic lower_count;
  logic same_count;
  logic older;

  assign lower_count = ent.count < best.count;
  assign same_count  = ent.count == best.count;
  assign older       = ent.stamp < best.stamp;

  always_comb begin
    res.match  = ent_valid && (ent.key == key);
    // Lowest count wins; among equal counts the oldest stamp wins.
    res.better = ent_valid && (!best.valid || lower_count || (same_count && older));
    res.free   = !ent_valid;
  end

endmodule
